// ----- rtl/assert_macros.svh -----
// Assertion macros for the transposer RTL (included by bmtp_emit).
// Checks are active in simulation and compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every clock edge out of reset.
`define BMTP_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("bmtp assertion failed");

// Check that a condition is followed by a consequence in the next cycle.
`define BMTP_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("bmtp assertion failed");

`else

`define BMTP_ASSERT(lbl, clk, rst_n, expr)
`define BMTP_ASSERT_NEXT(lbl, clk, rst_n, cond, cons)

`endif

`endif

// ----- rtl/bmtp_pkg.sv -----
// Shared types and constants for the bitmap row-to-page transposer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmtp_pkg;

    // Rows of a stripe held in the store; the eighth row arrives live
    localparam int STORE_ROWS = 7;

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH = 1'b0;
    localparam logic REG_ROW_STRIDE  = 1'b1;

    // One store word: the seven stored rows of one byte column
    typedef logic [STORE_ROWS-1:0][7:0] t_stripe;

    // One pending eighth-row byte and what it needs to expand
    typedef struct packed {
        logic [7:0] data;       // eighth-row bitmap byte
        logic [3:0] page;       // panel page
        logic [7:0] bcol;       // byte column
        logic [2:0] last_j;     // index of the last column that gives a result
        logic       last_page;  // page is the panel's last page
    } t_job;

endpackage

`default_nettype wire

// ----- rtl/bmtp_store.sv -----
// Stripe store: one word per byte column, byte-lane writes, registered read.
// Depends on bmtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmtp_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                               i_clk,
    input  wire  [bmtp_pkg::STORE_ROWS-1:0]   i_wr_lane,
    input  wire  [AW-1:0]                     i_wr_addr,
    input  wire  [7:0]                        i_wr_data,
    input  wire                               i_rd_en,
    input  wire  [AW-1:0]                     i_rd_addr,
    output bmtp_pkg::t_stripe                 o_rd_data
);

    bmtp_pkg::t_stripe mem [DEPTH];
    bmtp_pkg::t_stripe r_rd_data;

    // Write the enabled row lanes of one byte column
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < bmtp_pkg::STORE_ROWS; k++) begin
            if (i_wr_lane[k]) begin
                mem[i_wr_addr][k] <= i_wr_data;
            end
        end
    end

    // Read a whole column; hold the data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/bmtp_emit.sv -----
// Page byte emitter: expands one eighth-row byte into page bytes, one a beat,
// through a registered output stage. Depends on bmtp_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bmtp_emit (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_load,
    input  wire bmtp_pkg::t_job      i_job,
    input  wire bmtp_pkg::t_stripe   i_stripe,
    input  wire  [7:0]               i_image_width,
    output logic                     o_ready,
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    output logic [23:0]              m_axis_tdata,   // page_byte, page_index, column_index
    output logic                     m_axis_tlast,   // last_of_run
    output logic                     m_axis_tuser    // frame_done
);

    logic           r_busy;
    logic [2:0]     r_j;
    bmtp_pkg::t_job r_job;

    logic           r_ovalid;
    logic [23:0]    r_odata;
    logic           r_olast;
    logic           r_ouser;

    logic           adv;
    logic           done;
    logic [2:0]     bit_sel;
    logic [7:0]     page_byte;
    logic [8:0]     col;
    logic           frame_done;

    assign adv     = r_busy && (!r_ovalid || m_axis_tready);
    assign done    = adv && (r_j == r_job.last_j);
    assign o_ready = !r_busy || done;

    // Gather one column of the stripe; MSB of a row byte is column zero
    always_comb begin
        bit_sel = 3'd7 - r_j;
        for (int k = 0; k < bmtp_pkg::STORE_ROWS; k++) begin
            page_byte[k] = i_stripe[k][bit_sel];
        end
        page_byte[7] = r_job.data[bit_sel];
        col          = {r_job.bcol[5:0], r_j};
        frame_done   = r_job.last_page && ((col + 9'd1) == {1'b0, i_image_width});
    end

    // Hold the job and step through its columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_j    <= 3'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_j    <= 3'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (adv) begin
            r_j    <= r_j + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    // Output register: load a beat when free or drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_odata <= {6'd0, col[6:0], r_job.page[2:0], page_byte};
            r_olast <= (r_j == r_job.last_j);
            r_ouser <= frame_done;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

    `BMTP_ASSERT(a_load_when_ready, i_clk, i_rst_n, !i_load || o_ready)
    `BMTP_ASSERT(a_index_in_run, i_clk, i_rst_n, !r_busy || (r_j <= r_job.last_j))
    `BMTP_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, done && !i_load, !r_busy)
    `BMTP_ASSERT_NEXT(a_beat_follows_adv, i_clk, i_rst_n, adv, m_axis_tvalid)

endmodule

`default_nettype wire

// ----- rtl/bitmap_row_to_page_transposer_top.sv -----
// Bitmap row-to-page transposer: stripe store plus page byte emitter; uses bmtp_pkg.
// Page bytes leave through a registered output stage. Throughput: while the emitter is
// idle, one beat a cycle for stored rows and bytes past the width; an eighth-row beat
// holds the input until its 1 to 8 page bytes are issued, longer on output stalls.
// Synchronous active-low reset clears the counters, loads width 128 (capped) and
// stride 16; the stripe store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_row_to_page_transposer_top #(
    parameter int PANEL_WIDTH = 128,
    parameter int PANEL_PAGES = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_addr,
    input  wire  [7:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // row_byte
    input  wire         s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // page_byte, page_index, column_index
    output logic        m_axis_tlast,   // last_of_run
    output logic        m_axis_tuser    // frame_done
);

    localparam int BYTE_COLS  = (PANEL_WIDTH + 7) / 8;
    localparam int AW         = (BYTE_COLS > 1) ? $clog2(BYTE_COLS) : 1;
    localparam int TOTAL_ROWS = 8 * PANEL_PAGES;
    localparam int ROW_W      = $clog2(TOTAL_ROWS);
    localparam int WIDTH_RST  = (PANEL_WIDTH < 128) ? PANEL_WIDTH : 128;

    logic [7:0]       r_image_width;
    logic [7:0]       r_row_stride;
    logic [ROW_W-1:0] r_row;
    logic [7:0]       r_bcol;

    logic             accept;
    logic [ROW_W-1:0] cur_row;
    logic [7:0]       cur_bcol;
    logic [2:0]       sub;
    logic [3:0]       page;
    logic             in_range;
    logic [10:0]      rem;
    logic [7:0]       next_bcol;
    logic [ROW_W:0]   row_inc;
    logic             is_store_row;
    logic             load;
    logic [bmtp_pkg::STORE_ROWS-1:0] wr_lane;
    bmtp_pkg::t_job   job;
    bmtp_pkg::t_stripe stripe;
    logic             emit_ready;

    // Configuration writes; cap the width at the panel width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= 8'(WIDTH_RST);
            r_row_stride  <= 8'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bmtp_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= ({1'b0, i_cfg_data} > 9'(PANEL_WIDTH)) ?
                                     8'(PANEL_WIDTH) : i_cfg_data;
                end
                bmtp_pkg::REG_ROW_STRIDE: begin
                    r_row_stride <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = emit_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Decode the position of the incoming beat
    always_comb begin
        cur_row      = s_axis_tuser ? '0 : r_row;
        cur_bcol     = s_axis_tuser ? 8'd0 : r_bcol;
        sub          = cur_row[2:0];
        page         = 4'(cur_row >> 3);
        in_range     = ({1'b0, cur_bcol} < 9'(BYTE_COLS)) &&
                       ({cur_bcol, 3'b000} < {3'b000, r_image_width});
        rem          = {3'b000, r_image_width} - {cur_bcol, 3'b000};
        is_store_row = (sub != 3'd7);
        next_bcol    = cur_bcol + 8'd1;
        row_inc      = {1'b0, cur_row} + 1'b1;
        load         = accept && in_range && !is_store_row;
        wr_lane      = (accept && in_range && is_store_row) ?
                       (bmtp_pkg::STORE_ROWS'(1) << sub) : '0;

        job.data      = s_axis_tdata;
        job.page      = page;
        job.bcol      = cur_bcol;
        job.last_j    = (rem >= 11'd8) ? 3'd7 : (rem[2:0] - 3'd1);
        job.last_page = (page == 4'(PANEL_PAGES - 1));
    end

    // Advance the byte and row counters on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_bcol <= 8'd0;
        end else if (accept) begin
            if (next_bcol == r_row_stride) begin
                r_bcol <= 8'd0;
                r_row  <= (row_inc >= (ROW_W + 1)'(TOTAL_ROWS)) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                r_bcol <= next_bcol;
                r_row  <= cur_row;
            end
        end
    end

    bmtp_store #(
        .DEPTH (BYTE_COLS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_lane (wr_lane),
        .i_wr_addr (cur_bcol[AW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (load),
        .i_rd_addr (cur_bcol[AW-1:0]),
        .o_rd_data (stripe)
    );

    bmtp_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_job         (job),
        .i_stripe      (stripe),
        .i_image_width (r_image_width),
        .o_ready       (emit_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- verif/tb_bitmap_row_to_page_transposer_top.sv -----
// Testbench for bitmap_row_to_page_transposer_top: streams row-major bitmap bytes in,
// predicts the vertical page bytes in a scoreboard class and checks every output beat.
// Depends on bmtp_pkg and the transposer RTL.
`timescale 1ns / 1ps

module tb_bitmap_row_to_page_transposer_top;

    localparam int PANEL_W    = 128;
    localparam int PANEL_PG   = 8;
    localparam int BYTE_COLS  = PANEL_W / 8;
    localparam int TOTAL_ROWS = 8 * PANEL_PG;
    localparam int HOLD_LEN   = 80;

    typedef struct {
        logic [7:0] page_byte;
        logic [2:0] page_index;
        logic [6:0] column_index;
        logic       last_of_run;
        logic       frame_done;
    } t_page_result;

    // Transposer state mirror plus the queue of page bytes still owed by the block
    class t_page_scoreboard;
        logic [7:0]   stripe_rows [bmtp_pkg::STORE_ROWS][BYTE_COLS];
        bit           written [bmtp_pkg::STORE_ROWS][BYTE_COLS];
        int           row_pos;
        int           byte_pos;
        int           width_cfg;
        int           stride_cfg;
        t_page_result pending_pages[$];
        int           errors;

        function new();
            foreach (stripe_rows[r, c]) begin
                stripe_rows[r][c] = 8'h00;
                written[r][c]     = 1'b0;
            end
            row_pos    = 0;
            byte_pos   = 0;
            width_cfg  = PANEL_W;
            stride_cfg = 16;
            errors     = 0;
        endfunction

        function void set_reg(logic addr, logic [7:0] value);
            if (addr == bmtp_pkg::REG_IMAGE_WIDTH) begin
                width_cfg = (value > PANEL_W) ? PANEL_W : value;
            end else begin
                stride_cfg = value;
            end
        endfunction

        // True when a beat at the current position would read a never-written store entry
        function bit reads_unwritten(logic frame_start);
            int sub;
            int bcol;
            if (frame_start) return 1'b0;
            sub  = row_pos % 8;
            bcol = byte_pos;
            if (bcol >= BYTE_COLS || bcol * 8 >= width_cfg || sub < bmtp_pkg::STORE_ROWS)
                return 1'b0;
            for (int k = 0; k < bmtp_pkg::STORE_ROWS; k++) begin
                if (!written[k][bcol]) return 1'b1;
            end
            return 1'b0;
        endfunction

        // Store a stripe row byte or expand an eighth-row byte into page bytes
        function void note_bitmap_beat(logic [7:0] data, logic frame_start);
            int row;
            int bcol;
            int sub;
            int page;
            int col;
            int n_cols;
            int nxt;
            t_page_result res;
            if (frame_start) begin
                row_pos  = 0;
                byte_pos = 0;
            end
            row  = row_pos;
            bcol = byte_pos;
            sub  = row % 8;
            page = row / 8;
            if (bcol < BYTE_COLS && bcol * 8 < width_cfg) begin
                if (sub < bmtp_pkg::STORE_ROWS) begin
                    stripe_rows[sub][bcol] = data;
                    written[sub][bcol]     = 1'b1;
                end else begin
                    n_cols = width_cfg - bcol * 8;
                    if (n_cols > 8) n_cols = 8;
                    for (int j = 0; j < n_cols; j++) begin
                        col = bcol * 8 + j;
                        for (int k = 0; k < bmtp_pkg::STORE_ROWS; k++) begin
                            res.page_byte[k] = stripe_rows[k][bcol][7 - j];
                        end
                        res.page_byte[7]     = data[7 - j];
                        res.page_index       = page[2:0];
                        res.column_index     = col[6:0];
                        res.last_of_run      = (j == n_cols - 1);
                        res.frame_done       = (page == PANEL_PG - 1) && (col + 1 == width_cfg);
                        pending_pages.push_back(res);
                    end
                end
            end
            // Advance the position; the byte counter is 8 bits wide
            nxt = (bcol + 1) & 8'hFF;
            if (nxt == stride_cfg) begin
                byte_pos = 0;
                row_pos  = (row + 1 >= TOTAL_ROWS) ? 0 : row + 1;
            end else begin
                byte_pos = nxt;
            end
        endfunction

        function void match_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one output beat with the oldest owed page byte
        function void check_page_beat(logic [23:0] tdata, logic tlast, logic tuser);
            t_page_result want;
            if (pending_pages.size() == 0) begin
                $display("%0t: page beat with nothing expected, got data %06h last %0b user %0b",
                         $time, tdata, tlast, tuser);
                errors++;
                return;
            end
            want = pending_pages.pop_front();
            match_field("page_byte", want.page_byte, tdata[7:0]);
            match_field("page_index", want.page_index, tdata[10:8]);
            match_field("column_index", want.column_index, tdata[17:11]);
            match_field("last_of_run", want.last_of_run, tlast);
            match_field("frame_done", want.frame_done, tuser);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // row_byte
    logic        s_axis_tuser;   // frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // page_byte, page_index, column_index
    logic        m_axis_tlast;   // last_of_run
    logic        m_axis_tuser;   // frame_done

    t_page_scoreboard sb;
    bit tx_idling;
    bit rx_idling;
    bit hold_request;

    bitmap_row_to_page_transposer_top #(
        .PANEL_WIDTH(PANEL_W),
        .PANEL_PAGES(PANEL_PG)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // Offer one bitmap beat and hold it until accepted
    task automatic send_beat(input logic [7:0] data, input logic frame_start);
        int gap;
        logic fs;
        gap = pick_gap(tx_idling);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // Restart the frame rather than read store entries never written
        fs = frame_start | sb.reads_unwritten(frame_start);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= fs;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_bitmap_beat(data, fs);
    endtask

    // Hold the input idle until every owed page byte has come out
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_pages.size() != 0);
    endtask

    // Drain, let beats that give no output leave the pipe, then write a register
    task automatic write_reg(input logic addr, input logic [7:0] value);
        pause_until_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(addr, value);
    endtask

    // One setting: well-formed rows from a frame start, with some stray frame starts unless under pressure
    task automatic run_phase(input int n_items, input int width_val, input int stride_val,
                             input bit tx_gaps, input bit rx_gaps, input bit with_pressure);
        logic fs;
        write_reg(bmtp_pkg::REG_IMAGE_WIDTH, width_val[7:0]);
        write_reg(bmtp_pkg::REG_ROW_STRIDE, stride_val[7:0]);
        tx_idling = tx_gaps;
        rx_idling = rx_gaps;
        for (int i = 0; i < n_items; i++) begin
            if (with_pressure && i == 8) hold_request = 1'b1;
            if (with_pressure && i == 40) pause_until_drained();
            fs = (i == 0) || (!with_pressure && $urandom_range(0, 19) == 0);
            send_beat(8'($urandom_range(0, 255)), fs);
        end
    endtask

    // Output side: check each beat, stall at random, hold off long on request
    initial begin : page_sink
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_page_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_LEN;
            end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap(rx_idling);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        sb = new();
        tx_idling    = 1'b1;
        rx_idling    = 1'b1;
        hold_request = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= bmtp_pkg::REG_IMAGE_WIDTH;
        i_cfg_data    <= 8'h00;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full byte column: one stripe of eight single-byte rows
        write_reg(bmtp_pkg::REG_IMAGE_WIDTH, 8'd8);
        write_reg(bmtp_pkg::REG_ROW_STRIDE, 8'd1);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h55, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h5A, 1'b0);

        // Partial byte: only five columns give page bytes on page 1
        write_reg(bmtp_pkg::REG_IMAGE_WIDTH, 8'd5);
        send_beat(8'h3C, 1'b0);
        send_beat(8'hC3, 1'b0);
        send_beat(8'h0F, 1'b0);
        send_beat(8'hF0, 1'b0);
        send_beat(8'h99, 1'b0);
        send_beat(8'h66, 1'b0);
        send_beat(8'h7E, 1'b0);
        send_beat(8'hFF, 1'b0);

        // Width above the panel saturates; zero stride makes 256-byte rows
        write_reg(bmtp_pkg::REG_IMAGE_WIDTH, 8'hFF);
        write_reg(bmtp_pkg::REG_ROW_STRIDE, 8'h00);
        send_beat(8'h12, 1'b1);
        send_beat(8'hED, 1'b0);

        // Zero width consumes everything
        write_reg(bmtp_pkg::REG_IMAGE_WIDTH, 8'h00);
        send_beat(8'hA5, 1'b1);
        send_beat(8'h5A, 1'b0);

        // Whole frame with row wrap, long output hold-off and a drain pause
        run_phase(66, 8, 1, 1'b0, 1'b1, 1'b1);
        // Two byte columns, the second one possibly partial
        run_phase(16, $urandom_range(9, 16), 2, 1'b1, 1'b1, 1'b0);
        // Long rows: bytes past the panel are dropped
        run_phase(18, $urandom_range(0, 255),
                  $urandom_range(0, 1) ? 255 : $urandom_range(17, 254), 1'b1, 1'b0, 1'b0);
        // Back-to-back stretch, stride possibly too short for the width
        run_phase(10, $urandom_range(1, 16), $urandom_range(1, 3), 1'b0, 1'b0, 1'b0);

        pause_until_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_pages.size() == 0) begin
            $display("bitmap_row_to_page_transposer_top verification clean");
        end else begin
            $display("bitmap_row_to_page_transposer_top verification failed");
        end
        $finish;
    end

    // Bound the run well beyond the slowest legal pace
    initial begin : watchdog
        #4_000_000;
        $display("bitmap_row_to_page_transposer_top verification failed");
        $finish;
    end

endmodule
